// ----- rtl/core/fss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pkg
// shared types, constants and helper functions of the fuzzy subsequence scorer
// ----------------------------------------------------------------------------
package fss_pkg;

   localparam int MAX_PATTERN_DEFAULT = 64;

   localparam int CHAR_W    = 16;
   localparam int SCORE_W   = 20;
   localparam int WEIGHT_W  = 8;
   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_WEIGHTS = 6;

   // commands
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TARGET = 2'd2;
   localparam logic [CMD_W-1:0] CMD_EMPTY  = 2'd3;

   // weight register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MATCH       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WORD_START  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CONSECUTIVE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAP         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EXACT       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PREFIX      = 3'd5;

   // weight reset values
   localparam logic signed [WEIGHT_W-1:0] RST_MATCH       = 8'sd16;
   localparam logic signed [WEIGHT_W-1:0] RST_WORD_START  = 8'sd8;
   localparam logic signed [WEIGHT_W-1:0] RST_CONSECUTIVE = 8'sd4;
   localparam logic signed [WEIGHT_W-1:0] RST_GAP         = -8'sd1;
   localparam logic signed [WEIGHT_W-1:0] RST_EXACT       = 8'sd100;
   localparam logic signed [WEIGHT_W-1:0] RST_PREFIX      = 8'sd50;

   localparam logic signed [WEIGHT_W-1:0] CASE_BONUS = 8'sd2;

   localparam logic signed [SCORE_W-1:0] SCORE_ZERO = '0;
   localparam logic signed [SCORE_W-1:0] SCORE_MISS = -20'sd1;
   localparam logic signed [SCORE_W:0]   SUM_MAX    = 21'sd524287;
   localparam logic signed [SCORE_W:0]   SUM_MIN    = -21'sd524288;
   localparam logic signed [SCORE_W-1:0] SCORE_MAX  = 20'sd524287;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN  = -20'sd524288;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NUL     = 16'h0000;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_TAB     = 16'h0009;
   localparam logic [CHAR_W-1:0] CH_DASH    = 16'h002D;
   localparam logic [CHAR_W-1:0] CH_UNDER   = 16'h005F;
   localparam logic [CHAR_W-1:0] CH_DOT     = 16'h002E;
   localparam logic [CHAR_W-1:0] CH_COLON   = 16'h003A;
   localparam logic [CHAR_W-1:0] CH_SLASH   = 16'h002F;
   localparam logic [CHAR_W-1:0] CH_UP_A    = 16'h0041;
   localparam logic [CHAR_W-1:0] CH_UP_Z    = 16'h005A;
   localparam logic [CHAR_W-1:0] CH_LO_A    = 16'h0061;
   localparam logic [CHAR_W-1:0] CH_LO_Z    = 16'h007A;
   localparam logic [CHAR_W-1:0] CASE_DELTA = 16'h0020;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [CHAR_W-1:0] character;
      logic              last;
   } req_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic                      matched;
      logic                      pattern_overflow;
   } rsp_type;

   function automatic logic is_upper(input logic [CHAR_W-1:0] c);
      return (c >= CH_UP_A) && (c <= CH_UP_Z);
   endfunction

   function automatic logic is_lower(input logic [CHAR_W-1:0] c);
      return (c >= CH_LO_A) && (c <= CH_LO_Z);
   endfunction

   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      return is_upper(c) ? c + CASE_DELTA : c;
   endfunction

   // separator before, or a lower-to-upper camelCase step
   function automatic logic is_boundary(input logic [CHAR_W-1:0] prev,
                                        input logic [CHAR_W-1:0] curr);
      logic sep;
      sep = (prev == CH_NUL) || (prev == CH_SPACE) || (prev == CH_TAB) ||
            (prev == CH_DASH) || (prev == CH_UNDER) || (prev == CH_DOT) ||
            (prev == CH_COLON) || (prev == CH_SLASH);
      return sep || (is_lower(prev) && is_upper(curr));
   endfunction

   function automatic logic signed [SCORE_W-1:0] sat_add(
      input logic signed [SCORE_W-1:0]  a,
      input logic signed [WEIGHT_W-1:0] b);
      logic signed [SCORE_W:0] sum;
      sum = {a[SCORE_W-1], a} + {{(SCORE_W+1-WEIGHT_W){b[WEIGHT_W-1]}}, b};
      if (sum > SUM_MAX) begin
         return SCORE_MAX;
      end else if (sum < SUM_MIN) begin
         return SCORE_MIN;
      end
      return sum[SCORE_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fss_pattern_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pattern_ram
// pattern store: one write port, two registered read ports with write bypass
// ----------------------------------------------------------------------------
module fss_pattern_ram #(
   parameter int  DEPTH = fss_pkg::MAX_PATTERN_DEFAULT,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [fss_pkg::CHAR_W-1:0]  wr_data,
   input  wire logic                        rd_en,
   input  wire logic [AW-1:0]               rd_addr_a,
   input  wire logic [AW-1:0]               rd_addr_b,
   output logic      [fss_pkg::CHAR_W-1:0]  rd_data_a,
   output logic      [fss_pkg::CHAR_W-1:0]  rd_data_b
);
   import fss_pkg::*;

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_a_ff;
   logic [CHAR_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // same-cycle write wins so a fresh append is seen at once
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
         rd_data_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule
`default_nettype wire

// ----- rtl/core/fuzzy_subsequence_scorer.sv -----
// a word is taken into the input register and worked there; its result then waits in the result register
// throughput: one word per cycle, held back only while a result waits on rsp_ready
// the pattern char for the next step is prefetched from the store's two read ports
// reset: synchronous, active high; clears pattern length, flags, target state, weights
// the pattern store itself is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// streams target chars against a stored pattern, greedy subsequence match
// with case folding, word-start, consecutive and case bonuses, gap penalty,
// and an exact or prefix bonus on the last char
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer #(
   parameter int MAX_PATTERN = fss_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request words
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire fss_pkg::req_type              req_payload,
   // result words
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output fss_pkg::rsp_type                   rsp_payload,
   // weight registers
   input  wire logic                          csr_we,
   input  wire logic [fss_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fss_pkg::WEIGHT_W-1:0]  csr_wdata
);
   import fss_pkg::*;

   localparam int AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int PLW = $clog2(MAX_PATTERN + 1);   // pattern length / match index
   localparam int TLW = $clog2(MAX_PATTERN + 2);   // target length, saturates at max+1
   localparam logic [PLW-1:0] PLEN_MAX = PLW'(MAX_PATTERN);
   localparam logic [TLW-1:0] TLEN_MAX = TLW'(MAX_PATTERN);

   // ---------------------------------------------------------------------
   // weight registers
   // ---------------------------------------------------------------------
   logic signed [WEIGHT_W-1:0] w_match_ff, w_word_ff, w_consec_ff;
   logic signed [WEIGHT_W-1:0] w_gap_ff, w_exact_ff, w_prefix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_match_ff  <= RST_MATCH;
         w_word_ff   <= RST_WORD_START;
         w_consec_ff <= RST_CONSECUTIVE;
         w_gap_ff    <= RST_GAP;
         w_exact_ff  <= RST_EXACT;
         w_prefix_ff <= RST_PREFIX;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MATCH:       w_match_ff  <= csr_wdata;
            REG_WORD_START:  w_word_ff   <= csr_wdata;
            REG_CONSECUTIVE: w_consec_ff <= csr_wdata;
            REG_GAP:         w_gap_ff    <= csr_wdata;
            REG_EXACT:       w_exact_ff  <= csr_wdata;
            REG_PREFIX:      w_prefix_ff <= csr_wdata;
            default: ;  // indexes past the list are ignored
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------------
   logic    item_valid_ff;
   req_type item_ff;
   logic    proc;          // the registered word is worked this cycle

   assign proc      = item_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !item_valid_ff || proc;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_payload;
      end
   end

   // ---------------------------------------------------------------------
   // pattern and target state
   // ---------------------------------------------------------------------
   logic [PLW-1:0]            plen_ff, plen_in;
   logic                      ovf_ff, ovf_in;
   logic [PLW-1:0]            mi_ff, mi_in;
   logic [TLW-1:0]            tlen_ff, tlen_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [CHAR_W-1:0]         prev_char_ff, prev_char_in;
   logic                      word_start_ff, word_start_in;
   logic                      prev_hit_ff, prev_hit_in;
   logic                      prefix_ok_ff, prefix_ok_in;
   // pattern char at the match index; right after a target restart it is
   // the same entry as the one at the target position, so take it from there
   logic [CHAR_W-1:0]         pat_mi_ff, pat_mi_in;
   logic                      mi_from_pos_ff, mi_from_pos_in;

   // store ports: a holds entry mi+1, b holds entry at target position
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [AW-1:0]     ram_addr_a, ram_addr_b;
   logic [CHAR_W-1:0] pat_next, pat_pos;

   fss_pattern_ram #(
      .DEPTH (MAX_PATTERN)
   ) u_pattern_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (item_ff.character),
      .rd_en     (proc),
      .rd_addr_a (ram_addr_a),
      .rd_addr_b (ram_addr_b),
      .rd_data_a (pat_next),
      .rd_data_b (pat_pos)
   );

   // ---------------------------------------------------------------------
   // one target step
   // ---------------------------------------------------------------------
   logic [CHAR_W-1:0]         cur_pat, fc, prev;
   logic                      active, hit, bnd, ws_bonus, consec, same_case;
   logic                      is_target, restart;
   logic signed [SCORE_W-1:0] s_match, s_word, s_consec, s_case, s_step, s_final;
   logic [PLW-1:0]            mi_p1, mi_p2;
   logic [TLW-1:0]            tlen_p1, tlen_step, plen_ext;
   logic                      prefix_step;
   logic [PLW-1:0]            mi_step;
   logic                      emit;
   rsp_type                   rsp_in;

   always_comb begin
      is_target = (item_ff.command == CMD_TARGET);
      restart   = !is_target || item_ff.last;

      cur_pat  = mi_from_pos_ff ? pat_pos : pat_mi_ff;
      fc       = fold_char(item_ff.character);
      prev     = (tlen_ff == '0) ? CH_NUL : prev_char_ff;
      active   = (mi_ff < plen_ff);
      hit      = active && (fc == fold_char(cur_pat));
      bnd      = is_boundary(prev, item_ff.character);
      ws_bonus = word_start_ff || bnd;
      consec   = prev_hit_ff && (mi_ff != '0);
      same_case = (item_ff.character == cur_pat);

      // saturating after every add, in the same order as the scoring rules
      s_match  = sat_add(score_ff, w_match_ff);
      s_word   = ws_bonus  ? sat_add(s_match, w_word_ff)   : s_match;
      s_consec = consec    ? sat_add(s_word, w_consec_ff)  : s_word;
      s_case   = same_case ? sat_add(s_consec, CASE_BONUS) : s_consec;

      if (!active) begin
         s_step = score_ff;
      end else if (hit) begin
         s_step = s_case;
      end else begin
         s_step = sat_add(score_ff, w_gap_ff);
      end

      mi_step  = hit ? mi_ff + PLW'(1) : mi_ff;
      plen_ext = TLW'(plen_ff);
      prefix_step = prefix_ok_ff &&
                    !((tlen_ff < plen_ext) && (fc != fold_char(pat_pos)));
      tlen_step = (tlen_ff <= TLEN_MAX) ? tlen_ff + TLW'(1) : tlen_ff;

      // exact or prefix bonus on the completed target
      if (prefix_step && (tlen_step == plen_ext)) begin
         s_final = sat_add(s_step, w_exact_ff);
      end else if (prefix_step && (tlen_step > plen_ext)) begin
         s_final = sat_add(s_step, w_prefix_ff);
      end else begin
         s_final = s_step;
      end

      // next-state defaults: hold
      plen_in        = plen_ff;
      ovf_in         = ovf_ff;
      mi_in          = mi_ff;
      tlen_in        = tlen_ff;
      score_in       = score_ff;
      prev_char_in   = prev_char_ff;
      word_start_in  = word_start_ff;
      prev_hit_in    = prev_hit_ff;
      prefix_ok_in   = prefix_ok_ff;
      pat_mi_in      = pat_mi_ff;
      mi_from_pos_in = mi_from_pos_ff;
      ram_we         = 1'b0;
      ram_waddr      = plen_ff[AW-1:0];

      // prefetch addresses for the following word
      mi_p1   = mi_ff + PLW'(1);
      mi_p2   = mi_ff + PLW'(2);
      tlen_p1 = tlen_ff + TLW'(1);
      if (restart) begin
         ram_addr_a = AW'(1);
         ram_addr_b = '0;
      end else begin
         ram_addr_a = hit ? mi_p2[AW-1:0] : mi_p1[AW-1:0];
         ram_addr_b = tlen_p1[AW-1:0];
      end

      emit   = 1'b0;
      rsp_in = '{score: SCORE_ZERO, matched: 1'b1, pattern_overflow: ovf_ff};

      if (proc) begin
         case (item_ff.command)
            CMD_CLEAR: begin
               plen_in = '0;
               ovf_in  = 1'b0;
            end
            CMD_APPEND: begin
               if (plen_ff < PLEN_MAX) begin
                  ram_we  = 1'b1;
                  plen_in = plen_ff + PLW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            CMD_EMPTY: begin
               emit = 1'b1;
               if (plen_ff != '0) begin
                  rsp_in.score   = SCORE_MISS;
                  rsp_in.matched = 1'b0;
               end
            end
            default: begin  // target char
               mi_in          = mi_step;
               tlen_in        = tlen_step;
               score_in       = s_step;
               prev_char_in   = item_ff.character;
               prefix_ok_in   = prefix_step;
               pat_mi_in      = hit ? pat_next : cur_pat;
               mi_from_pos_in = 1'b0;
               if (active) begin
                  prev_hit_in   = hit;
                  word_start_in = hit ? 1'b0 : bnd;
               end
               if (item_ff.last) begin
                  emit = 1'b1;
                  if (plen_ff == '0) begin
                     rsp_in.score = SCORE_ZERO;
                  end else if (mi_step < plen_ff) begin
                     rsp_in.score   = SCORE_MISS;
                     rsp_in.matched = 1'b0;
                  end else begin
                     rsp_in.score = s_final;
                  end
               end
            end
         endcase

         // every word but a mid-target char drops the target in progress
         if (restart) begin
            mi_in          = '0;
            tlen_in        = '0;
            score_in       = SCORE_ZERO;
            prev_char_in   = CH_NUL;
            word_start_in  = 1'b1;
            prev_hit_in    = 1'b0;
            prefix_ok_in   = 1'b1;
            mi_from_pos_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff        <= '0;
         ovf_ff         <= 1'b0;
         mi_ff          <= '0;
         tlen_ff        <= '0;
         score_ff       <= SCORE_ZERO;
         prev_char_ff   <= CH_NUL;
         word_start_ff  <= 1'b1;
         prev_hit_ff    <= 1'b0;
         prefix_ok_ff   <= 1'b1;
         mi_from_pos_ff <= 1'b1;
      end else begin
         plen_ff        <= plen_in;
         ovf_ff         <= ovf_in;
         mi_ff          <= mi_in;
         tlen_ff        <= tlen_in;
         score_ff       <= score_in;
         prev_char_ff   <= prev_char_in;
         word_start_ff  <= word_start_in;
         prev_hit_ff    <= prev_hit_in;
         prefix_ok_ff   <= prefix_ok_in;
         mi_from_pos_ff <= mi_from_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_mi_ff <= pat_mi_in;
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire
